// ===== rtl/dcts_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the task scheduler.
`timescale 1ns / 1ps

package dcts_pkg;

    localparam int NODES  = 64;
    localparam int FANOUT = 16;

    // Fixed field widths
    localparam int NW   = 6;
    localparam int OPW  = 3;
    localparam int CNTW = 7;
    localparam int STW  = 3;

    localparam logic [CNTW-1:0] CNT_MAX = {CNTW{1'b1}};

    // Derived storage widths
    localparam int NAW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CCW  = $clog2(FANOUT + 1);
    localparam int LW   = $clog2(NODES + 1);
    localparam int KMAX = (NODES > FANOUT) ? NODES : FANOUT;
    localparam int KW   = $clog2(KMAX + 1);
    localparam int CTD  = NODES * FANOUT;
    localparam int CTAW = (CTD > 1) ? $clog2(CTD) : 1;

    typedef enum logic [OPW-1:0] {
        OP_CONNECT   = 3'd0,
        OP_MARK_INIT = 3'd1,
        OP_MARK_TERM = 3'd2,
        OP_START     = 3'd3,
        OP_FINISH    = 3'd4,
        OP_POP       = 3'd5
    } op_t;

    typedef enum logic [STW-1:0] {
        ST_OK           = 3'd0,
        ST_DUP_EDGE     = 3'd1,
        ST_FANOUT_FULL  = 3'd2,
        ST_STACK_FULL   = 3'd3,
        ST_STACK_EMPTY  = 3'd4,
        ST_START_FULL   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CN_SCAN,
        S_CN_COMMIT,
        S_FN_SCAN,
        S_ST_RUN,
        S_POP,
        S_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic fin;
        logic conn_commit;
        logic mark_init;
        logic mark_term;
        logic start_init;
        logic start_run;
        logic fin_term;
        logic pop;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [OPW-1:0] opcode;
        logic           a_oor;
        logic           b_oor;
        logic           cc_zero;
        logic           scan_done;
        logic           start_done;
    } dp_stat_t;

    typedef struct packed {
        logic [CNTW-1:0] init_cnt;
        logic [CNTW-1:0] pend_cnt;
    } dep_t;

endpackage

// ===== rtl/dcts_req_if.sv =====
// Request channel: opcode and node operands with valid/ready.
`timescale 1ns / 1ps

interface dcts_req_if;
    logic                     valid;
    logic                     ready;
    logic [dcts_pkg::OPW-1:0] opcode;
    logic [dcts_pkg::NW-1:0]  node_a;
    logic [dcts_pkg::NW-1:0]  node_b;

    modport source (output valid, output opcode, output node_a, output node_b, input ready);
    modport sink   (input valid, input opcode, input node_a, input node_b, output ready);
endinterface

// ===== rtl/dcts_rsp_if.sv =====
// Response channel: one result per request with valid/ready.
`timescale 1ns / 1ps

interface dcts_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [dcts_pkg::NW-1:0]   ready_node;
    logic                      ready_valid;
    logic                      cycle_done;
    logic [dcts_pkg::CNTW-1:0] pushed_count;
    logic [dcts_pkg::STW-1:0]  status;

    modport source (output valid, output ready_node, output ready_valid, output cycle_done,
                    output pushed_count, output status, input ready);
    modport sink   (input valid, input ready_node, input ready_valid, input cycle_done,
                    input pushed_count, input status, output ready);
endinterface

// ===== rtl/dcts_ctrl.sv =====
// Sequencer: steps each request through decode, scan or push loops, and the response register.
`timescale 1ns / 1ps

module dcts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output dcts_pkg::dp_cmd_t  cmd,
    input  dcts_pkg::dp_stat_t stat
);
    import dcts_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                case (op_t'(stat.opcode))
                    OP_CONNECT:
                    begin
                        if (!stat.a_oor && !stat.b_oor)
                        begin
                            state_next = S_CN_SCAN;
                        end
                    end
                    OP_MARK_INIT:
                    begin
                        cmd.mark_init = !stat.a_oor;
                    end
                    OP_MARK_TERM:
                    begin
                        cmd.mark_term = 1'b1;
                    end
                    OP_START:
                    begin
                        cmd.start_init = 1'b1;
                        state_next     = S_ST_RUN;
                    end
                    OP_FINISH:
                    begin
                        if (!stat.a_oor)
                        begin
                            state_next = S_FN_SCAN;
                        end
                    end
                    OP_POP:
                    begin
                        state_next = S_POP;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_CN_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_CN_COMMIT;
                end
            end
            S_CN_COMMIT:
            begin
                cmd.conn_commit = 1'b1;
                state_next      = S_RESP;
            end
            S_FN_SCAN:
            begin
                cmd.scan = 1'b1;
                cmd.fin  = 1'b1;
                if (stat.cc_zero)
                begin
                    // leaf node: count down the remaining terminals instead
                    cmd.fin_term = 1'b1;
                    state_next   = S_RESP;
                end
                else if (stat.scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_ST_RUN:
            begin
                cmd.start_run = 1'b1;
                if (stat.start_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // hold until the response register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/dcts_dp.sv =====
// Datapath: child table, dependency counts, start list, ready stack and result registers.
`timescale 1ns / 1ps

module dcts_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dcts_pkg::OPW-1:0]   opcode,
    input  logic [dcts_pkg::NW-1:0]    node_a,
    input  logic [dcts_pkg::NW-1:0]    node_b,
    input  dcts_pkg::dp_cmd_t          cmd,
    output dcts_pkg::dp_stat_t         stat,
    output logic [dcts_pkg::NW-1:0]    ready_node,
    output logic                       ready_valid,
    output logic                       cycle_done,
    output logic [dcts_pkg::CNTW-1:0]  pushed_count,
    output logic [dcts_pkg::STW-1:0]   status
);
    import dcts_pkg::*;

    // Latched request
    logic [OPW-1:0] opcode_reg;
    logic [NW-1:0]  a_reg;
    logic [NW-1:0]  b_reg;
    logic [NAW-1:0] a_idx;
    logic [NAW-1:0] b_idx;

    // Loop index shared by the child scan and the start-list walk
    logic [KW-1:0] k_reg, k_next;

    // Child counts per node
    logic [CCW-1:0]   cc_mem [NODES];
    logic [NODES-1:0] cc_vld_reg;
    logic [CCW-1:0]   cc_rd_reg;
    logic             cc_rv_reg;
    logic [CCW-1:0]   cc_val;
    logic             cc_we;

    // Initial and pending dependency counts per node
    dep_t             dep_mem [NODES];
    logic [NODES-1:0] dep_vld_reg;
    dep_t             dep_rd_reg;
    logic             dep_rv_reg;
    dep_t             dep_cur;
    logic [NAW-1:0]   dep_raddr;
    logic             dep_we;
    logic [NAW-1:0]   dep_waddr;
    dep_t             dep_wdata;
    logic [CNTW-1:0]  init_sat;

    // Child table
    logic [NW-1:0]   ct_mem [CTD];
    logic [NW-1:0]   ct_rd_reg;
    logic [CTAW-1:0] ct_base;
    logic [CTAW-1:0] ct_raddr;
    logic [CTAW-1:0] ct_waddr;
    logic            ct_we;

    // Scan pipeline
    logic          scan_issue;
    logic          ct_pv_reg, ct_pv_next;
    logic          dp_pv_reg, dp_pv_next;
    logic [NW-1:0] dp_c_reg;
    logic          dup_reg, dup_next;

    // Start list
    logic [NW-1:0] sl_mem [NODES];
    logic [LW-1:0] sl_len_reg, sl_len_next;
    logic [NW-1:0] sl_rd_reg;
    logic          sl_we;
    logic          sl_pv_reg, sl_pv_next;
    logic          start_issue;

    // Ready stack
    logic [NW-1:0]  rs_mem [NODES];
    logic [LW-1:0]  rs_depth_reg, rs_depth_next;
    logic [NW-1:0]  rs_rd_reg;
    logic [NAW-1:0] rs_raddr;
    logic           rs_we;
    logic           push_en;
    logic [NW-1:0]  push_node;

    // Terminal countdown
    logic [CNTW-1:0] term_total_reg, term_total_next;
    logic [CNTW-1:0] term_left_reg, term_left_next;

    // Result being built and response register
    logic [NW-1:0]   res_node_reg, res_node_next;
    logic            res_valid_reg, res_valid_next;
    logic            res_done_reg, res_done_next;
    logic [CNTW-1:0] res_pushed_reg, res_pushed_next;
    status_t         res_status_reg, res_status_next;
    logic [NW-1:0]   out_node_reg;
    logic            out_valid_reg;
    logic            out_done_reg;
    logic [CNTW-1:0] out_pushed_reg;
    status_t         out_status_reg;

    assign a_idx = NAW'(a_reg);
    assign b_idx = NAW'(b_reg);

    assign cc_val  = cc_rv_reg ? cc_rd_reg : '0;
    assign dep_cur = dep_rv_reg ? dep_rd_reg : '0;

    assign ct_base  = CTAW'(a_idx) * CTAW'(FANOUT);
    assign ct_raddr = ct_base + CTAW'(k_reg);
    assign ct_waddr = ct_base + CTAW'(cc_val);

    assign scan_issue  = cmd.scan && (k_reg < KW'(cc_val));
    assign start_issue = cmd.start_run && (k_reg < KW'(sl_len_reg));

    // Stage one of finish reads the child's counts; otherwise watch node_b
    assign dep_raddr = (cmd.fin && ct_pv_reg) ? NAW'(ct_rd_reg) : b_idx;
    assign rs_raddr  = NAW'(rs_depth_reg - LW'(1));

    assign init_sat = (dep_cur.init_cnt < CNT_MAX) ? dep_cur.init_cnt + CNTW'(1)
                                                   : dep_cur.init_cnt;

    assign ct_pv_next = scan_issue;
    assign dp_pv_next = cmd.fin && ct_pv_reg;
    assign sl_pv_next = start_issue;

    assign stat.opcode     = opcode_reg;
    assign stat.a_oor      = int'(a_reg) >= NODES;
    assign stat.b_oor      = int'(b_reg) >= NODES;
    assign stat.cc_zero    = (cc_val == '0);
    assign stat.scan_done  = (k_reg >= KW'(cc_val)) && !ct_pv_reg && !dp_pv_reg;
    assign stat.start_done = (k_reg >= KW'(sl_len_reg)) && !sl_pv_reg;

    always_comb
    begin
        k_next          = k_reg;
        dup_next        = dup_reg;
        sl_len_next     = sl_len_reg;
        rs_depth_next   = rs_depth_reg;
        term_total_next = term_total_reg;
        term_left_next  = term_left_reg;
        res_node_next   = res_node_reg;
        res_valid_next  = res_valid_reg;
        res_done_next   = res_done_reg;
        res_pushed_next = res_pushed_reg;
        res_status_next = res_status_reg;
        cc_we           = 1'b0;
        ct_we           = 1'b0;
        sl_we           = 1'b0;
        rs_we           = 1'b0;
        dep_we          = 1'b0;
        dep_waddr       = b_idx;
        dep_wdata       = dep_cur;
        push_en         = 1'b0;
        push_node       = sl_rd_reg;

        if (cmd.load)
        begin
            k_next          = '0;
            dup_next        = 1'b0;
            res_node_next   = '0;
            res_valid_next  = 1'b0;
            res_done_next   = 1'b0;
            res_pushed_next = '0;
            res_status_next = ST_OK;
        end
        else if (scan_issue || start_issue)
        begin
            k_next = k_reg + KW'(1);
        end

        // Duplicate edge check during the connect scan
        if (cmd.scan && !cmd.fin && ct_pv_reg && (ct_rd_reg == b_reg))
        begin
            dup_next = 1'b1;
        end

        if (cmd.conn_commit)
        begin
            if (dup_reg)
            begin
                res_status_next = ST_DUP_EDGE;
            end
            else if (cc_val >= CCW'(FANOUT))
            begin
                res_status_next = ST_FANOUT_FULL;
            end
            else
            begin
                ct_we              = 1'b1;
                cc_we              = 1'b1;
                dep_we             = 1'b1;
                dep_waddr          = b_idx;
                dep_wdata.init_cnt = init_sat;
                dep_wdata.pend_cnt = init_sat;
            end
        end

        if (cmd.mark_init)
        begin
            if (sl_len_reg >= LW'(NODES))
            begin
                res_status_next = ST_START_FULL;
            end
            else
            begin
                sl_we       = 1'b1;
                sl_len_next = sl_len_reg + LW'(1);
            end
        end

        if (cmd.mark_term)
        begin
            if (term_total_reg < CNT_MAX)
            begin
                term_total_next = term_total_reg + CNTW'(1);
            end
            term_left_next = term_total_next;
        end

        if (cmd.start_init)
        begin
            term_left_next = term_total_reg;
        end

        if (cmd.fin_term && (term_left_reg != '0))
        begin
            term_left_next = term_left_reg - CNTW'(1);
            res_done_next  = (term_left_reg == CNTW'(1));
        end

        // Stage two of finish: count down the child, reload and push at one
        if (dp_pv_reg && (dep_cur.pend_cnt != '0))
        begin
            dep_we    = 1'b1;
            dep_waddr = NAW'(dp_c_reg);
            if (dep_cur.pend_cnt == CNTW'(1))
            begin
                dep_wdata.pend_cnt = dep_cur.init_cnt;
                push_en            = 1'b1;
                push_node          = dp_c_reg;
            end
            else
            begin
                dep_wdata.pend_cnt = dep_cur.pend_cnt - CNTW'(1);
            end
        end

        if (sl_pv_reg)
        begin
            push_en   = 1'b1;
            push_node = sl_rd_reg;
        end

        if (push_en)
        begin
            if (rs_depth_reg >= LW'(NODES))
            begin
                res_status_next = ST_STACK_FULL;
            end
            else
            begin
                rs_we           = 1'b1;
                rs_depth_next   = rs_depth_reg + LW'(1);
                res_pushed_next = res_pushed_reg + CNTW'(1);
            end
        end

        if (cmd.pop)
        begin
            if (rs_depth_reg == '0)
            begin
                res_status_next = ST_STACK_EMPTY;
            end
            else
            begin
                rs_depth_next  = rs_depth_reg - LW'(1);
                res_node_next  = rs_rd_reg;
                res_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg          <= '0;
            dup_reg        <= 1'b0;
            ct_pv_reg      <= 1'b0;
            dp_pv_reg      <= 1'b0;
            sl_pv_reg      <= 1'b0;
            sl_len_reg     <= '0;
            rs_depth_reg   <= '0;
            term_total_reg <= '0;
            term_left_reg  <= '0;
            cc_vld_reg     <= '0;
            dep_vld_reg    <= '0;
        end
        else
        begin
            k_reg          <= k_next;
            dup_reg        <= dup_next;
            ct_pv_reg      <= ct_pv_next;
            dp_pv_reg      <= dp_pv_next;
            sl_pv_reg      <= sl_pv_next;
            sl_len_reg     <= sl_len_next;
            rs_depth_reg   <= rs_depth_next;
            term_total_reg <= term_total_next;
            term_left_reg  <= term_left_next;
            if (cc_we)
            begin
                cc_vld_reg[a_idx] <= 1'b1;
            end
            if (dep_we)
            begin
                dep_vld_reg[dep_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opcode_reg <= opcode;
            a_reg      <= node_a;
            b_reg      <= node_b;
        end
        dp_c_reg       <= ct_rd_reg;
        res_node_reg   <= res_node_next;
        res_valid_reg  <= res_valid_next;
        res_done_reg   <= res_done_next;
        res_pushed_reg <= res_pushed_next;
        res_status_reg <= res_status_next;
        if (cmd.emit)
        begin
            out_node_reg   <= res_node_reg;
            out_valid_reg  <= res_valid_reg;
            out_done_reg   <= res_done_reg;
            out_pushed_reg <= res_pushed_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Memories
    always_ff @(posedge clk)
    begin
        cc_rd_reg <= cc_mem[a_idx];
        cc_rv_reg <= cc_vld_reg[a_idx];
        if (cc_we)
        begin
            cc_mem[a_idx] <= cc_val + CCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        dep_rd_reg <= dep_mem[dep_raddr];
        dep_rv_reg <= dep_vld_reg[dep_raddr];
        if (dep_we)
        begin
            dep_mem[dep_waddr] <= dep_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        ct_rd_reg <= ct_mem[ct_raddr];
        if (ct_we)
        begin
            ct_mem[ct_waddr] <= b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sl_rd_reg <= sl_mem[NAW'(k_reg)];
        if (sl_we)
        begin
            sl_mem[NAW'(sl_len_reg)] <= a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_rd_reg <= rs_mem[rs_raddr];
        if (rs_we)
        begin
            rs_mem[NAW'(rs_depth_reg)] <= push_node;
        end
    end

    assign ready_node   = out_node_reg;
    assign ready_valid  = out_valid_reg;
    assign cycle_done   = out_done_reg;
    assign pushed_count = out_pushed_reg;
    assign status       = out_status_reg;

endmodule

// ===== rtl/dependency_count_task_scheduler.sv =====
// Top level of the dependency-counting task scheduler: sequencer plus datapath.
//
//   channel   dir   handshake        payload
//   req       in    valid / ready    opcode, node_a, node_b
//   rsp       out   valid / ready    ready_node, ready_valid, cycle_done, pushed_count, status
//
// One request at a time: req.ready is high only while the sequencer is idle.
// Each request passes through decode, then a connect scan and commit, finish scan, start
// walk or pop step, then the response state; loops read one child or start entry per cycle.
// A finished response waits in the output register, so the next request is taken
// while rsp is stalled. Reset is asynchronous and clears counts with no clearing pass.
`timescale 1ns / 1ps

module dependency_count_task_scheduler (
    input logic          clk,
    input logic          rst_n,
    dcts_req_if.sink     req,
    dcts_rsp_if.source   rsp
);
    import dcts_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dcts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    dcts_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .opcode       (req.opcode),
        .node_a       (req.node_a),
        .node_b       (req.node_b),
        .cmd          (cmd),
        .stat         (stat),
        .ready_node   (rsp.ready_node),
        .ready_valid  (rsp.ready_valid),
        .cycle_done   (rsp.cycle_done),
        .pushed_count (rsp.pushed_count),
        .status       (rsp.status)
    );

endmodule
